[rtl/itad_pkg.sv]
package itad_pkg;

    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = BIN_W / 4;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int SHIFT_W    = $clog2(BIN_W);
    localparam int REM_W      = $clog2(DEC_DIGITS + 1);
    localparam int PRE_W      = 2;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_ALPHA = 8'd55;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_X     = 8'd120;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_GRAB,
        S_SKIP,
        S_PREFIX,
        S_EMIT
    } state_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10)
            code = ASCII_ZERO + {4'd0, nib};
        else
            code = ASCII_ALPHA + {4'd0, nib};
        return code;
    endfunction

endpackage

[rtl/itad_bcd.sv]
module itad_bcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [itad_pkg::BIN_W-1:0]  bin_in,
    output logic                        done,
    output logic [itad_pkg::BCD_W-1:0]  bcd
);
    import itad_pkg::*;

    logic                busy_reg, busy_next;
    logic [SHIFT_W-1:0]  cnt_reg, cnt_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = bin_in;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SHIFT_W'(BIN_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = busy_reg && (cnt_reg == SHIFT_W'(BIN_W - 1));
    assign bcd  = bcd_reg;

endmodule

[rtl/int_to_ascii_dec_hex.sv]
// Converts a 32-bit word to ASCII text, one character per output beat, with
// last high on the final character. cmd 0 gives signed decimal ("-" for
// negatives, no leading zeros, "0" for zero); cmd 1 gives "0x" and uppercase
// hex without leading zeros ("0x0" for zero). One word is handled at a time
// and in_stall is high from acceptance until the last character is loaded
// into the output register. A decimal word is accepted, converted in the
// shift-and-add-3 binary-to-BCD unit and its digits loaded; up to 9 leading
// zeros are skipped, then the "-" of a negative word and the digits are sent.
// A hex word needs no conversion: it is accepted, its leading zero nibbles
// are skipped, then "0x" and the digits are sent. A character is loaded only
// when the output register is empty or is being read out, so a stall holds it.
// The output register frees the next word to enter while the final beat waits.
module int_to_ascii_dec_hex (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic [itad_pkg::BIN_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 char_code,
    output logic                       last
);
    import itad_pkg::*;

    state_t              state_reg, state_next;
    logic                hex_reg, hex_next;
    logic [PRE_W-1:0]    pre_reg, pre_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [BCD_W-1:0]    dig_reg, dig_next;
    logic                ov_reg, ov_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                slot_free;
    logic                dab_start;
    logic                dab_done;
    logic [BCD_W-1:0]    dab_bcd;
    logic [BIN_W-1:0]    mag;
    logic [3:0]          top_dig;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !ov_reg || !out_stall;
    assign top_dig   = dig_reg[BCD_W-1 -: 4];
    assign mag       = value[BIN_W-1] ? (~value + BIN_W'(1)) : value;
    assign dab_start = accept && (cmd == CMD_DEC);

    itad_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dab_start),
        .bin_in (mag),
        .done   (dab_done),
        .bcd    (dab_bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (cmd == CMD_HEX) ? S_SKIP : S_CONV;
            end
            S_CONV:
            begin
                if (dab_done)
                    state_next = S_GRAB;
            end
            S_GRAB:
                state_next = S_SKIP;
            S_SKIP:
            begin
                if (!(rem_reg > REM_W'(1) && top_dig == 4'd0))
                    state_next = (pre_reg != '0) ? S_PREFIX : S_EMIT;
            end
            S_PREFIX:
            begin
                if (slot_free && pre_reg == PRE_W'(1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free && rem_reg == REM_W'(1))
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        hex_next  = hex_reg;
        pre_next  = pre_reg;
        rem_next  = rem_reg;
        dig_next  = dig_reg;
        ov_next   = ov_reg && out_stall;
        char_next = char_reg;
        last_next = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hex_next = (cmd == CMD_HEX);
                    if (cmd == CMD_HEX)
                    begin
                        pre_next = PRE_W'(2);
                        rem_next = REM_W'(HEX_DIGITS);
                        dig_next = {value, {(BCD_W - BIN_W){1'b0}}};
                    end
                    else
                    begin
                        pre_next = value[BIN_W-1] ? PRE_W'(1) : PRE_W'(0);
                        rem_next = REM_W'(DEC_DIGITS);
                    end
                end
            end
            S_GRAB:
                dig_next = dab_bcd;
            S_SKIP:
            begin
                // drop a leading zero, but keep at least one digit
                if (rem_reg > REM_W'(1) && top_dig == 4'd0)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - 1'b1;
                end
            end
            S_PREFIX:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    last_next = 1'b0;
                    if (!hex_reg)
                        char_next = ASCII_MINUS;
                    else if (pre_reg == PRE_W'(2))
                        char_next = ASCII_ZERO;
                    else
                        char_next = ASCII_X;
                    pre_next = pre_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    char_next = digit_to_ascii(top_dig);
                    last_next = (rem_reg == REM_W'(1));
                    dig_next  = {dig_reg[BCD_W-5:0], 4'd0};
                    rem_next  = rem_reg - 1'b1;
                end
            end
            default:
            begin
                ov_next = ov_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            pre_reg   <= '0;
            rem_reg   <= '0;
            hex_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pre_reg   <= pre_next;
            rem_reg   <= rem_next;
            hex_reg   <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

[verif/tb_top.sv]
module tb_top;

    import itad_pkg::*;

    localparam int IDLE_PCT       = 29;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic [7:0] code;
        logic       eot;
    } char_beat_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              cmd       = CMD_DEC;
    logic [BIN_W-1:0]  value     = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        char_code;
    logic              last;

    bit                send_gaps = 1'b0;
    bit                sink_gaps = 1'b0;
    int                fail_count = 0;
    int                quiet_cycles = 0;
    char_beat_t        pending_chars[$];
    char_beat_t        want_beat;

    int_to_ascii_dec_hex uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    always #1 clk = ~clk;

    // Build the text of one word and queue its characters.
    function automatic void queue_text(input logic mode, input logic [BIN_W-1:0] w);
        logic [7:0]       text[$];
        logic [7:0]       digits[$];
        logic [BIN_W-1:0] mag;
        logic [3:0]       nib;
        bit               started;
        char_beat_t       beat;
        started = 1'b0;
        if (mode == CMD_DEC)
        begin
            mag = w;
            if (w[BIN_W-1])
            begin
                text.push_back(ASCII_MINUS);
                mag = ~w + 1'b1;
            end
            do
            begin
                digits.push_front(8'(ASCII_ZERO + mag % 10));
                mag = mag / 10;
            end
            while (mag != 0);
            foreach (digits[i])
                text.push_back(digits[i]);
        end
        else
        begin
            text.push_back(ASCII_ZERO);
            text.push_back(ASCII_X);
            for (int pos = HEX_DIGITS - 1; pos >= 0; pos--)
            begin
                nib = w[pos*4 +: 4];
                if (nib != 0 || started || pos == 0)
                begin
                    started = 1'b1;
                    text.push_back(nib < 10 ? 8'(ASCII_ZERO + nib)
                                            : 8'(ASCII_ALPHA + nib));
                end
            end
        end
        foreach (text[i])
        begin
            beat.code = text[i];
            beat.eot  = (i == text.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Send one word; hold the payload until the block takes it.
    task automatic send_word(input logic mode, input logic [BIN_W-1:0] w);
        while (send_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= mode;
        value    <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [BIN_W-1:0] random_word();
        logic [BIN_W-1:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: ;
            1: w = w >> $urandom_range(BIN_W - 1);
            2: w = -(w >> $urandom_range(BIN_W - 1));
            default: w = (32'd1 << $urandom_range(BIN_W - 1)) - $urandom_range(1);
        endcase
        return w;
    endfunction

    always @(posedge clk)
    begin
        out_stall <= sink_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    // Predict on each input beat, then check each output beat.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            queue_text(cmd, value);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
                log_failure($sformatf("unexpected char 0x%02h last=%0b", char_code, last));
            else
            begin
                want_beat = pending_chars.pop_front();
                if (char_code !== want_beat.code || last !== want_beat.eot)
                    log_failure($sformatf(
                        "char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                        want_beat.code, want_beat.eot, char_code, last));
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_corner_words();
        send_word(CMD_DEC, 32'd0);
        send_word(CMD_DEC, 32'd1);
        send_word(CMD_DEC, 32'd9);
        send_word(CMD_DEC, 32'd10);
        send_word(CMD_DEC, 32'hFFFF_FFFF);
        send_word(CMD_DEC, 32'h7FFF_FFFF);
        send_word(CMD_DEC, 32'h8000_0000);
        send_word(CMD_DEC, 32'h8000_0001);
        send_word(CMD_DEC, 32'd999999999);
        send_word(CMD_DEC, 32'd1000000000);
        send_word(CMD_DEC, -32'sd1000000000);
        send_word(CMD_HEX, 32'h0);
        send_word(CMD_HEX, 32'h9);
        send_word(CMD_HEX, 32'hA);
        send_word(CMD_HEX, 32'hF);
        send_word(CMD_HEX, 32'h10);
        send_word(CMD_HEX, 32'h0FFF_FFFF);
        send_word(CMD_HEX, 32'h1000_0000);
        send_word(CMD_HEX, 32'h8000_0000);
        send_word(CMD_HEX, 32'hFFFF_FFFF);
        send_word(CMD_HEX, 32'h1234_5678);
        send_word(CMD_HEX, 32'hABCD_EF09);
    endtask

    // No bench-inserted gaps on either side.
    task automatic test_streaming();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        repeat (60)
            send_word($urandom_range(1), random_word());
    endtask

    task automatic test_random_traffic();
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (180)
            send_word($urandom_range(1), random_word());
    endtask

    initial
    begin
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_words();
        test_streaming();
        test_random_traffic();
        in_valid <= 1'b0;
        // let the predictor queue the final word before waiting on the queue
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_chars.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
